// File: hw/rtl/npsch_pkg.sv
// shared types and constants for the non-preemptive priority scheduler
// used by npsch_cell and the nonpreemptive_priority_scheduler top level
`default_nettype none

package npsch_pkg;

    localparam int PRIO_W       = 8;   // priority field width
    localparam int SLOT_FIELD_W = 3;   // slot field width on the stream ports
    localparam int IDX_W        = 6;   // slot index carried down the cell row (up to 64 slots)

    // best candidate so far, handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [PRIO_W-1:0] prio;
        logic [IDX_W-1:0]  idx;
    } cand_t;

    // per-slot status seen by the controller
    typedef struct packed {
        logic loaded;
        logic ready;    // arrived, loaded, work left
        logic done;     // loaded, no work left
        logic rem_one;  // exactly one unit left
    } cell_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PICK,
        ST_CALC,
        ST_EMIT
    } state_t;

endpackage : npsch_pkg

`default_nettype wire

// File: hw/rtl/nonpreemptive_priority_scheduler.sv
// top level of the non-preemptive priority scheduler: stream ports, controller,
// time counter, result calculation and output register
// depends on npsch_pkg and npsch_cell
//
// usage:
//   the input stream carries one item per transfer; s_tuser is the op flag
//   (0 load a job slot, 1 advance one time unit). a load writes one slot cell
//   and gives no result; a load to a slot of SLOTS or above is dropped.
//   a tick gives exactly one result transfer on the m_ side.
// processing:
//   a load is written to its slot cell as it is taken and does not leave the
//   idle state. for a tick the best-candidate value ripples through the row of
//   SLOTS slot cells one cell per cycle, then pick, turnaround and wait stages
//   follow before its result is registered. one item is in work at a time;
//   after a tick the next transfer is taken once its result has gone into the free output register.
// reset (aresetn low, synchronous): time counter back to 1, processor free,
//   all slots unloaded, output register empty. slot contents are not cleared.
// stall: the output register holds one result; a load is still taken while
//   it waits, and a tick finishes its work but holds before updating state
//   until the previous result has been taken.
`default_nettype none

module nonpreemptive_priority_scheduler #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // slot, arrival, burst, priority_req (low bit up), zero padded
    input  wire logic [((npsch_pkg::SLOT_FIELD_W + 2*TIME_BITS + npsch_pkg::PRIO_W + 7)/8)*8-1:0]
                      s_tdata,
    // op
    input  wire logic s_tuser,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // time_unit, cpu_idle, running_slot, waiting_mask, done_mask, job_finished,
    // finish_time, turnaround, wait_time, all_done (low bit up), zero padded
    output logic [((4*TIME_BITS + 2*SLOTS + npsch_pkg::SLOT_FIELD_W + 3 + 7)/8)*8-1:0]
                      m_tdata
);
    import npsch_pkg::*;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int M_RAW_W  = 4*TIME_BITS + 2*SLOTS + SLOT_FIELD_W + 3;
    localparam int M_DATA_W = ((M_RAW_W + 7)/8)*8;
    localparam int OFS_ARR  = SLOT_FIELD_W;
    localparam int OFS_BUR  = OFS_ARR + TIME_BITS;
    localparam int OFS_PRI  = OFS_BUR + TIME_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // input fields
    logic                    in_op;
    logic [SLOT_FIELD_W-1:0] in_slot;
    logic [TIME_BITS-1:0]    in_arrival;
    logic [TIME_BITS-1:0]    in_burst;
    logic [PRIO_W-1:0]       in_prio;

    assign in_op      = s_tuser;
    assign in_slot    = s_tdata[SLOT_FIELD_W-1:0];
    assign in_arrival = s_tdata[OFS_ARR +: TIME_BITS];
    assign in_burst   = s_tdata[OFS_BUR +: TIME_BITS];
    assign in_prio    = s_tdata[OFS_PRI +: PRIO_W];

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 busy_reg, busy_next;
    logic [SLOT_W-1:0]    cur_reg, cur_next;
    logic                 eff_busy_reg, eff_busy_next;
    logic [SLOT_W-1:0]    eff_cur_reg, eff_cur_next;
    logic                 fin_reg, fin_next;
    logic [TIME_BITS-1:0] fin_t_reg, fin_t_next;
    logic [TIME_BITS-1:0] arr_sel_reg, arr_sel_next;
    logic [TIME_BITS-1:0] bur_sel_reg, bur_sel_next;
    logic [TIME_BITS-1:0] tat_reg, tat_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic in_xfer, load_acc, tick_acc, commit;
    logic [SLOTS-1:0] wr_en, dec_en;
    logic [SLOTS-1:0] waiting_mask, done_before, done_after, loaded_vec;
    logic             all_done;
    logic [TIME_BITS-1:0] wait_val;

    cand_t                cand_chain [SLOTS+1];
    cell_stat_t           stat       [SLOTS];
    logic [TIME_BITS-1:0] arrival_q  [SLOTS];
    logic [TIME_BITS-1:0] burst_q    [SLOTS];

    assign cand_chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        if (i < (1 << SLOT_FIELD_W)) begin : g_wr
            assign wr_en[i] = load_acc && (in_slot == SLOT_FIELD_W'(i));
        end else begin : g_nowr
            assign wr_en[i] = 1'b0;
        end

        assign dec_en[i] = commit && eff_busy_reg && (eff_cur_reg == SLOT_W'(i));

        npsch_cell #(
            .IDX       (i),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .wr_en      (wr_en[i]),
            .wr_arrival (in_arrival),
            .wr_burst   (in_burst),
            .wr_prio    (in_prio),
            .dec_en     (dec_en[i]),
            .time_now   (time_reg),
            .cand_in    (cand_chain[i]),
            .cand_out   (cand_chain[i+1]),
            .stat       (stat[i]),
            .arrival_q  (arrival_q[i]),
            .burst_q    (burst_q[i])
        );

        assign loaded_vec[i]   = stat[i].loaded;
        assign done_before[i]  = stat[i].done;
        assign done_after[i]   = stat[i].done || (dec_en[i] && stat[i].rem_one);
        assign waiting_mask[i] = stat[i].ready &&
                                 !(eff_busy_reg && (eff_cur_reg == SLOT_W'(i)));
    end

    assign in_xfer  = s_tvalid && s_tready;
    assign load_acc = in_xfer && !in_op;
    assign tick_acc = in_xfer && in_op;
    assign all_done = (loaded_vec != '0) && ((loaded_vec & ~done_after) == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (tick_acc) state_next = ST_SWEEP;
            ST_SWEEP: if (cnt_reg == SLOT_W'(SLOTS-1)) state_next = ST_PICK;
            ST_PICK:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_EMIT;
            ST_EMIT:  if (commit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_EMIT:  commit   = !m_tvalid_reg || m_tready;
            ST_SWEEP, ST_PICK, ST_CALC: ;
            default:  ;
        endcase
    end

    // datapath
    always_comb begin
        cnt_next      = (state_reg == ST_SWEEP) ? cnt_reg + SLOT_W'(1) : '0;
        time_next     = time_reg;
        busy_next     = busy_reg;
        cur_next      = cur_reg;
        eff_busy_next = eff_busy_reg;
        eff_cur_next  = eff_cur_reg;
        fin_next      = fin_reg;
        fin_t_next    = fin_t_reg;
        arr_sel_next  = arr_sel_reg;
        bur_sel_next  = bur_sel_reg;
        tat_next      = tat_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        wait_val      = (tat_reg > bur_sel_reg) ? tat_reg - bur_sel_reg : '0;

        // reloading the running slot frees the processor
        if (load_acc && busy_reg && wr_en[cur_reg]) begin
            busy_next = 1'b0;
        end

        if (state_reg == ST_PICK) begin
            if (busy_reg) begin
                eff_busy_next = 1'b1;
                eff_cur_next  = cur_reg;
            end else begin
                eff_busy_next = cand_chain[SLOTS].found;
                eff_cur_next  = cand_chain[SLOTS].idx[SLOT_W-1:0];
            end
            fin_next     = eff_busy_next && stat[eff_cur_next].rem_one;
            fin_t_next   = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + TIME_BITS'(1);
            arr_sel_next = arrival_q[eff_cur_next];
            bur_sel_next = burst_q[eff_cur_next];
        end

        if (state_reg == ST_CALC) begin
            tat_next = (fin_t_reg > arr_sel_reg) ? fin_t_reg - arr_sel_reg : '0;
        end

        if (commit) begin
            busy_next     = eff_busy_reg && !fin_reg;
            cur_next      = eff_cur_reg;
            time_next     = (time_reg == TIME_MAX) ? TIME_MAX : time_reg + TIME_BITS'(1);
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_DATA_W'({
                all_done,
                fin_reg ? wait_val  : {TIME_BITS{1'b0}},
                fin_reg ? tat_reg   : {TIME_BITS{1'b0}},
                fin_reg ? fin_t_reg : {TIME_BITS{1'b0}},
                fin_reg,
                done_before,
                waiting_mask,
                eff_busy_reg ? SLOT_FIELD_W'(eff_cur_reg) : {SLOT_FIELD_W{1'b0}},
                !eff_busy_reg,
                time_reg
            });
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            time_reg     <= TIME_BITS'(1);
            busy_reg     <= 1'b0;
            cur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            time_reg     <= time_next;
            busy_reg     <= busy_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        eff_busy_reg <= eff_busy_next;
        eff_cur_reg  <= eff_cur_next;
        fin_reg      <= fin_next;
        fin_t_reg    <= fin_t_next;
        arr_sel_reg  <= arr_sel_next;
        bur_sel_reg  <= bur_sel_next;
        tat_reg      <= tat_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : nonpreemptive_priority_scheduler

`default_nettype wire

// File: hw/rtl/npsch_cell.sv
// one job slot: holds arrival, burst, remaining work and priority,
// and merges itself into the best-candidate value passed along the row
// depends on npsch_pkg
`default_nettype none

module npsch_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [TIME_BITS-1:0]          wr_arrival,
    input  wire logic [TIME_BITS-1:0]          wr_burst,
    input  wire logic [npsch_pkg::PRIO_W-1:0]  wr_prio,
    input  wire logic                          dec_en,
    input  wire logic [TIME_BITS-1:0]          time_now,
    input  wire npsch_pkg::cand_t              cand_in,
    output npsch_pkg::cand_t                   cand_out,
    output npsch_pkg::cell_stat_t              stat,
    output logic [TIME_BITS-1:0]               arrival_q,
    output logic [TIME_BITS-1:0]               burst_q
);
    import npsch_pkg::*;

    logic                 loaded_reg;
    logic [TIME_BITS-1:0] arrival_reg;
    logic [TIME_BITS-1:0] burst_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [PRIO_W-1:0]    prio_reg;
    cand_t                cand_reg;
    cand_t                cand_next;
    logic                 own_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= 1'b0;
        end else if (wr_en) begin
            loaded_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            arrival_reg <= wr_arrival;
            burst_reg   <= wr_burst;
            rem_reg     <= wr_burst;
            prio_reg    <= wr_prio;
        end else if (dec_en) begin
            rem_reg <= rem_reg - TIME_BITS'(1);
        end
    end

    always_comb begin
        own_ready = loaded_reg && (arrival_reg <= time_now) && (rem_reg != '0);
    end

    // strict compare keeps the lower slot on a tie
    always_comb begin
        if (own_ready && (!cand_in.found || (prio_reg < cand_in.prio))) begin
            cand_next.found = 1'b1;
            cand_next.prio  = prio_reg;
            cand_next.idx   = IDX_W'(IDX);
        end else begin
            cand_next = cand_in;
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
    end

    assign cand_out     = cand_reg;
    assign stat.loaded  = loaded_reg;
    assign stat.ready   = own_ready;
    assign stat.done    = loaded_reg && (rem_reg == '0);
    assign stat.rem_one = (rem_reg == TIME_BITS'(1));
    assign arrival_q    = arrival_reg;
    assign burst_q      = burst_reg;

endmodule : npsch_cell

`default_nettype wire
